// ===== design/sica_pkg.sv =====
// Shared types, widths and codes for the sparse-input convolution accumulator.
// Used by the channel interfaces and every module of the block but sica_ram; no dependencies.
package sica_pkg;

    // Field widths of the channels.
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned WIDX_W = 8;
    localparam int unsigned VAL_W  = 16;
    localparam int unsigned COL_W  = 6;
    localparam int unsigned POS_W  = 12;
    localparam int unsigned ROW_W  = 6;
    localparam int unsigned ACC_W  = 40;
    localparam int unsigned PROD_W = 2 * VAL_W;

    // Configuration register widths.
    localparam int unsigned KDIM_W = 5;
    localparam int unsigned ODIM_W = 7;
    localparam int unsigned CFG_W  = 7;
    localparam int unsigned CFG_IDX_W = 2;

    // Storage sizes and defaults.
    localparam int unsigned WSTORE_DEPTH = 256;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned DEF_MAX_OUT_ROWS    = 64;
    localparam int unsigned DEF_MAX_OUT_COLS    = 64;
    localparam int unsigned DEF_MAX_KERNEL_ROWS = 16;
    localparam int unsigned DEF_MAX_KERNEL_COLS = 16;

    // Command codes of an input beat.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_ACC  = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_COLS = 2'd0,
        CFG_KERNEL_ROWS = 2'd1,
        CFG_OUT_ROWS    = 2'd2,
        CFG_OUT_COLS    = 2'd3
    } t_cfg_idx;

    // Effective (clamped) configuration.
    typedef struct packed {
        logic [KDIM_W-1:0] kernel_cols;
        logic [KDIM_W-1:0] kernel_rows;
        logic [ODIM_W-1:0] out_rows;
        logic [ODIM_W-1:0] out_cols;
    } t_cfg;

    // One classified task handed from the front end to the back end.
    typedef struct packed {
        t_cmd               op;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               in_range;
        logic [POS_W-1:0]   base_row;
        logic [KDIM_W-1:0]  offs;
        logic [VAL_W-1:0]   value;
        logic [WIDX_W-1:0]  widx;
    } t_task;

endpackage

// ===== design/sica_in_if.sv =====
// Input channel of the accumulator: valid/ready handshake with the command payload.
// Depends on sica_pkg for the field widths.
interface sica_in_if;
    import sica_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [WIDX_W-1:0]        weight_index;
    logic signed [VAL_W-1:0]  weight_value;
    logic [COL_W-1:0]         column;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  nz_value;
    logic [ROW_W-1:0]         out_row;

    modport source (
        output valid, cmd, weight_index, weight_value, column, position, nz_value, out_row,
        input  ready
    );

    modport sink (
        input  valid, cmd, weight_index, weight_value, column, position, nz_value, out_row,
        output ready
    );
endinterface

// ===== design/sica_out_if.sv =====
// Result channel of the accumulator: valid/ready handshake with one accumulator value.
// Depends on sica_pkg for the field width.
interface sica_out_if;
    import sica_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ACC_W-1:0]  out_value;

    modport source (
        output valid, out_value,
        input  ready
    );

    modport sink (
        input  valid, out_value,
        output ready
    );
endinterface

// ===== design/sparse_input_conv_accumulator_unit.sv =====
// Top level of the sparse-input convolution accumulator: configuration registers,
// front end, task queue and back end. Depends on sica_pkg, the channel interfaces,
// sica_front, sica_fifo and sica_back.
//
// Usage:
//   i_in_ch carries commands: load a kernel weight, accumulate one nonzero, or read
//   and clear one output accumulator. o_out_ch carries one 40-bit Q24.16 value for
//   every read; no other command gives a result. Beats move when valid and ready
//   are both high. Configuration goes in through i_cfg_we/i_cfg_idx/i_cfg_data; the
//   user must write it only while the block is idle; the block does not check this.
//   After reset the accumulator store is cleared one entry per cycle; i_in_ch.ready
//   stays low meanwhile, while configuration writes are taken. In the front end a
//   nonzero passes the 12-step serial divider that splits the position, and no new
//   beat is taken until the division ends. In the back end one kernel row per cycle
//   goes through the accumulator read-modify-write, and the next task starts only
//   once the pipeline has drained; the queue between them lets the front end work
//   ahead. When the receiver stalls, the result waits in the output register; loads
//   and accumulates before the next read continue, and that read waits at the head
//   of the queue for the register to empty.
module sparse_input_conv_accumulator_unit
    import sica_pkg::*;
#(
    parameter int unsigned MAX_OUT_ROWS    = DEF_MAX_OUT_ROWS,
    parameter int unsigned MAX_OUT_COLS    = DEF_MAX_OUT_COLS,
    parameter int unsigned MAX_KERNEL_ROWS = DEF_MAX_KERNEL_ROWS,
    parameter int unsigned MAX_KERNEL_COLS = DEF_MAX_KERNEL_COLS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    sica_in_if.sink              i_in_ch,
    sica_out_if.source           o_out_ch
);

    logic [KDIM_W-1:0] r_kernel_cols;
    logic [KDIM_W-1:0] r_kernel_rows;
    logic [ODIM_W-1:0] r_out_rows;
    logic [ODIM_W-1:0] r_out_cols;

    t_cfg  cfg;
    logic  clearing;
    logic  push;
    t_task push_task;
    logic  full;
    logic  pop;
    t_task head;
    logic  empty;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_cols <= KDIM_W'(3);
            r_kernel_rows <= KDIM_W'(3);
            r_out_rows    <= ODIM_W'(6);
            r_out_cols    <= ODIM_W'(6);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KERNEL_COLS: r_kernel_cols <= i_cfg_data[KDIM_W-1:0];
                CFG_KERNEL_ROWS: r_kernel_rows <= i_cfg_data[KDIM_W-1:0];
                CFG_OUT_ROWS:    r_out_rows    <= i_cfg_data[ODIM_W-1:0];
                CFG_OUT_COLS:    r_out_cols    <= i_cfg_data[ODIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp each register to one through its maximum.
    always_comb begin
        cfg.kernel_cols = (r_kernel_cols == '0) ? KDIM_W'(1)
                        : (32'(r_kernel_cols) > MAX_KERNEL_COLS) ? KDIM_W'(MAX_KERNEL_COLS)
                        : r_kernel_cols;
        cfg.kernel_rows = (r_kernel_rows == '0) ? KDIM_W'(1)
                        : (32'(r_kernel_rows) > MAX_KERNEL_ROWS) ? KDIM_W'(MAX_KERNEL_ROWS)
                        : r_kernel_rows;
        cfg.out_rows    = (r_out_rows == '0) ? ODIM_W'(1)
                        : (32'(r_out_rows) > MAX_OUT_ROWS) ? ODIM_W'(MAX_OUT_ROWS)
                        : r_out_rows;
        cfg.out_cols    = (r_out_cols == '0) ? ODIM_W'(1)
                        : (32'(r_out_cols) > MAX_OUT_COLS) ? ODIM_W'(MAX_OUT_COLS)
                        : r_out_cols;
    end

    sica_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_clearing (clearing),
        .i_in_ch    (i_in_ch),
        .o_push     (push),
        .o_task     (push_task),
        .i_full     (full)
    );

    sica_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (push_task),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    sica_back #(
        .MAX_OUT_ROWS (MAX_OUT_ROWS),
        .MAX_OUT_COLS (MAX_OUT_COLS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_head     (head),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_out_ch   (o_out_ch)
    );

endmodule

// ===== design/sica_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sica_ram #(
    parameter  int unsigned WIDTH = 16,
    parameter  int unsigned DEPTH = 256,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sica_fifo.sv =====
// Small task queue between the front and back ends, first-word fall-through.
// Depends on sica_pkg for the task type.
module sica_fifo
    import sica_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    output logic  o_full,
    input  logic  i_pop,
    output t_task o_head,
    output logic  o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_task          r_slot [DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_task;
        end
    end

endmodule

// ===== design/sica_front.sv =====
// Front end: accepts input beats, classifies them and splits the packed position
// with a bit-serial divider. Depends on sica_pkg and sica_in_if.
module sica_front
    import sica_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_clearing,
    sica_in_if.sink i_in_ch,
    output logic   o_push,
    output t_task  o_task,
    input  logic   i_full
);

    localparam int unsigned CNT_W = $clog2(POS_W);

    typedef enum logic {
        FS_IDLE,
        FS_DIV
    } t_state;

    t_state            r_state;
    logic              r_hold;
    logic [CNT_W-1:0]  r_cnt;
    t_task             r_task;
    logic [POS_W-1:0]  r_quo;
    logic [KDIM_W-1:0] r_rem;

    logic              accept;
    logic              push;
    logic [KDIM_W:0]   trial;
    logic              ge;
    logic [KDIM_W-1:0] n_rem;
    logic [POS_W-1:0]  n_quo;
    logic              last_step;
    logic              acc_keep;

    // Handshake: the holding register may be refilled in the cycle it drains.
    assign push    = r_hold && !i_full;
    assign i_in_ch.ready = (r_state == FS_IDLE) && !i_clearing && (!r_hold || !i_full);
    assign accept  = i_in_ch.valid && i_in_ch.ready;
    assign o_push  = push;
    assign o_task  = r_task;
    assign acc_keep = ({1'b0, i_in_ch.column} < i_cfg.out_cols);

    // One restoring division step per cycle, most significant bit first.
    always_comb begin
        trial = {r_rem, r_quo[POS_W-1]};
        ge    = (trial >= {1'b0, i_cfg.kernel_cols});
        n_rem = ge ? KDIM_W'(trial - {1'b0, i_cfg.kernel_cols}) : KDIM_W'(trial);
        n_quo = {r_quo[POS_W-2:0], ge};
        last_step = (r_cnt == CNT_W'(POS_W - 1));
    end

    // State and holding-register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_hold  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                FS_IDLE: begin
                    if (accept) begin
                        case (i_in_ch.cmd)
                            CMD_LOAD, CMD_READ: begin
                                r_hold <= 1'b1;
                            end
                            CMD_ACC: begin
                                r_hold <= 1'b0;
                                if (acc_keep) begin
                                    r_state <= FS_DIV;
                                    r_cnt   <= '0;
                                end
                            end
                            default: begin
                                r_hold <= 1'b0;
                            end
                        endcase
                    end else if (push) begin
                        r_hold <= 1'b0;
                    end
                end
                FS_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (last_step) begin
                        r_hold  <= 1'b1;
                        r_state <= FS_IDLE;
                    end
                end
                default: begin
                    r_state <= FS_IDLE;
                end
            endcase
        end
    end

    // Task payload and divider datapath.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_task.op       <= t_cmd'(i_in_ch.cmd);
            r_task.col      <= i_in_ch.column;
            r_task.row      <= i_in_ch.out_row;
            r_task.in_range <= ({1'b0, i_in_ch.out_row} < i_cfg.out_rows) && acc_keep;
            r_task.widx     <= i_in_ch.weight_index;
            r_task.value    <= (i_in_ch.cmd == CMD_LOAD) ? i_in_ch.weight_value
                                                         : i_in_ch.nz_value;
            r_quo           <= i_in_ch.position;
            r_rem           <= '0;
        end else if (r_state == FS_DIV) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            if (last_step) begin
                r_task.base_row <= n_quo;
                r_task.offs     <= n_rem;
            end
        end
    end

endmodule

// ===== design/sica_back.sv =====
// Back end: weight and accumulator stores, the per-row multiply-accumulate pipeline,
// read-and-clear, the clearing pass after reset and the result register.
// Depends on sica_pkg, sica_out_if and sica_ram.
module sica_back
    import sica_pkg::*;
#(
    parameter int unsigned MAX_OUT_ROWS = DEF_MAX_OUT_ROWS,
    parameter int unsigned MAX_OUT_COLS = DEF_MAX_OUT_COLS
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  t_task  i_head,
    input  logic   i_empty,
    output logic   o_pop,
    output logic   o_clearing,
    sica_out_if.source o_out_ch
);

    localparam int unsigned ACC_DEPTH = MAX_OUT_ROWS * MAX_OUT_COLS;
    localparam int unsigned ACC_AW    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
    localparam int unsigned RW        = POS_W + 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } t_state;

    // Control registers.
    t_state             r_state;
    logic [ACC_AW-1:0]  r_clr;
    logic [KDIM_W-1:0]  r_l;
    logic               r_s1_valid;
    logic               r_s1_read;
    logic               r_s2_valid;
    logic               r_out_valid;

    // Payload registers.
    t_task                    r_cur;
    logic signed [RW-1:0]     r_row;
    logic [WIDX_W-1:0]        r_widx;
    logic                     r_s1_inrange;
    logic [ACC_AW-1:0]        r_s1_addr;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic [ACC_W-1:0]         r_s2_acc;
    logic [ACC_AW-1:0]        r_s2_addr;
    logic [ACC_W-1:0]         r_out_data;

    // Memory ports.
    logic               acc_we;
    logic [ACC_AW-1:0]  acc_waddr;
    logic [ACC_W-1:0]   acc_wdata;
    logic [ACC_AW-1:0]  acc_raddr;
    logic [ACC_W-1:0]   acc_rdata;
    logic               w_we;
    logic [VAL_W-1:0]   w_rdata;

    logic               can_start;
    logic               pop;
    logic               pop_acc;
    logic               pop_read;
    logic               row_ok;
    logic               issue;
    logic               run_last;
    logic [ACC_AW-1:0]  run_addr;
    logic [ACC_AW-1:0]  read_addr;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W:0]    sum;
    logic [ACC_W-1:0]         sat;

    sica_ram #(
        .WIDTH (ACC_W),
        .DEPTH (ACC_DEPTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    sica_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WSTORE_DEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_head.widx),
        .i_wdata (i_head.value),
        .i_raddr (r_widx),
        .o_rdata (w_rdata)
    );

    // Task start: one task at a time, after the pipeline has drained.
    always_comb begin
        can_start = (r_state == ST_IDLE) && !i_empty && !r_s1_valid && !r_s2_valid;
        pop       = 1'b0;
        case (i_head.op)
            CMD_LOAD: pop = can_start;
            CMD_ACC:  pop = can_start;
            CMD_READ: pop = can_start && !r_out_valid;
            default:  pop = can_start;
        endcase
        pop_acc  = pop && (i_head.op == CMD_ACC);
        pop_read = pop && (i_head.op == CMD_READ);
        w_we     = pop && (i_head.op == CMD_LOAD);
    end

    // Row sequencing: one kernel row per cycle, rows outside the output are skipped.
    always_comb begin
        row_ok    = !r_row[RW-1] && (r_row[POS_W-1:0] < POS_W'(i_cfg.out_rows));
        issue     = (r_state == ST_RUN) && row_ok;
        run_last  = (r_l == i_cfg.kernel_rows - KDIM_W'(1));
        run_addr  = ACC_AW'(32'(r_row[POS_W-1:0]) * MAX_OUT_COLS + 32'(r_cur.col));
        read_addr = ACC_AW'(32'(i_head.row) * MAX_OUT_COLS + 32'(i_head.col));
        acc_raddr = (r_state == ST_RUN) ? run_addr : read_addr;
    end

    // Multiply, then add with saturation to the 40-bit range.
    always_comb begin
        prod = $signed(r_cur.value) * $signed(w_rdata);
        sum  = $signed({r_s2_acc[ACC_W-1], r_s2_acc})
             + $signed({{(ACC_W + 1 - PROD_W){r_s2_prod[PROD_W-1]}}, r_s2_prod});
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat = sum[ACC_W-1:0];
        end
    end

    // Accumulator write port: clearing sweep, accumulate write-back or read clear.
    always_comb begin
        acc_we    = 1'b0;
        acc_waddr = r_s2_addr;
        acc_wdata = sat;
        if (r_state == ST_CLEAR) begin
            acc_we    = 1'b1;
            acc_waddr = r_clr;
            acc_wdata = '0;
        end else if (r_s2_valid) begin
            acc_we    = 1'b1;
        end else if (r_s1_valid && r_s1_read && r_s1_inrange) begin
            acc_we    = 1'b1;
            acc_waddr = r_s1_addr;
            acc_wdata = '0;
        end
    end

    // State machine, pipeline valids and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_l         <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_read   <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + ACC_AW'(1);
                    if (r_clr == ACC_AW'(ACC_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (pop_acc) begin
                        r_l     <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_l <= r_l + KDIM_W'(1);
                    if (run_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            r_s1_valid <= issue || pop_read;
            r_s1_read  <= pop_read;
            r_s2_valid <= r_s1_valid && !r_s1_read;
            if (r_s1_valid && r_s1_read) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (pop_acc) begin
            r_cur  <= i_head;
            r_row  <= $signed({1'b0, i_head.base_row});
            r_widx <= WIDX_W'(i_head.offs);
        end else if (r_state == ST_RUN) begin
            r_row  <= r_row - RW'(1);
            r_widx <= r_widx + WIDX_W'(i_cfg.kernel_cols);
        end
        r_s1_addr    <= acc_raddr;
        r_s1_inrange <= i_head.in_range;
        r_s2_prod    <= prod;
        r_s2_acc     <= acc_rdata;
        r_s2_addr    <= r_s1_addr;
        if (r_s1_valid && r_s1_read) begin
            r_out_data <= r_s1_inrange ? acc_rdata : '0;
        end
    end

    assign o_pop              = pop;
    assign o_clearing         = (r_state == ST_CLEAR);
    assign o_out_ch.valid     = r_out_valid;
    assign o_out_ch.out_value = r_out_data;

    // No task starts while the store is being cleared.
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !pop)
        else $error("task taken during clearing pass");

    // A read result never lands on a result that is still waiting.
    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_read) |-> !r_out_valid)
        else $error("read result overwrites pending result");

    // The write-back stage never competes with the clearing sweep.
    a_no_wb_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!r_s2_valid && !r_s1_valid))
        else $error("pipeline active during clearing pass");

    // A started accumulate runs its rows next.
    a_acc_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_acc |=> (r_state == ST_RUN))
        else $error("accumulate task did not start its rows");

endmodule
